FILE: hw/rtl/assert_macros.svh
// Assertion helper macros for the grid distance block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a property holds on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Same check, also active while reset is high.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

FILE: hw/rtl/gbfs_pkg.sv
// ----------------------------------------------------------------------------
// gbfs_pkg
// Shared types and constants of the grid wavefront distance block.
// ----------------------------------------------------------------------------
package gbfs_pkg;
   localparam int GridWidth  = 32;
   localparam int GridHeight = 16;
   localparam int XW = 5;
   localparam int YW = 4;
   localparam int DW = 10;

   localparam logic [1:0] OP_WRITE   = 2'd0;
   localparam logic [1:0] OP_COMPUTE = 2'd1;
   localparam logic [1:0] OP_READ    = 2'd2;
   localparam logic [1:0] OP_NONE    = 2'd3;

   localparam logic [1:0] ST_REACH   = 2'd0;
   localparam logic [1:0] ST_BLOCKED = 2'd1;
   localparam logic [1:0] ST_UNREACH = 2'd2;

   localparam logic [0:0] REG_SRC_X = 1'b0;
   localparam logic [0:0] REG_SRC_Y = 1'b1;

   typedef struct packed {
      logic [1:0]    operation;
      logic [XW-1:0] cell_x;
      logic [YW-1:0] cell_y;
      logic          blocked;
   } req_type;

   typedef struct packed {
      logic [DW-1:0] distance;
      logic [1:0]    cell_state;
   } rsp_type;

   // Controls broadcast to every row of cells
   typedef struct packed {
      logic          clear;    // drop all reached bits
      logic          seed;     // mark the source cell
      logic          step;     // grow the wavefront one layer
      logic          wr;       // obstacle write
      logic [YW-1:0] wr_y;
      logic [XW-1:0] wr_x;
      logic          wr_blk;
      logic [YW-1:0] src_y;
      logic [XW-1:0] src_x;
   } row_ctl_type;
endpackage

FILE: hw/rtl/gbfs_row.sv
// ----------------------------------------------------------------------------
// gbfs_row
// One row of grid cells: obstacle and reached bits per cell. Each step a free
// unreached cell becomes reached if any 4-neighbor was reached.
// ----------------------------------------------------------------------------
module gbfs_row
   import gbfs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [YW-1:0]          row_id,
   input  row_ctl_type            ctl,
   input  logic [GridWidth-1:0]   above_reach,
   input  logic [GridWidth-1:0]   below_reach,
   output logic [GridWidth-1:0]   reach,
   output logic [GridWidth-1:0]   blk,
   output logic                   grew
);
   logic [GridWidth-1:0] blk_ff, blk_in, reach_ff, reach_in, near;

   // Neighbor reach within the row and from adjacent rows
   assign near = (reach_ff << 1) | (reach_ff >> 1) | above_reach | below_reach;

   always_comb begin
      blk_in   = blk_ff;
      reach_in = reach_ff;
      if (ctl.wr && ctl.wr_y == row_id) begin
         blk_in[ctl.wr_x] = ctl.wr_blk;
      end
      if (ctl.clear) begin
         reach_in = '0;
      end else if (ctl.seed) begin
         if (ctl.src_y == row_id && !blk_ff[ctl.src_x]) begin
            reach_in[ctl.src_x] = 1'b1;
         end
      end else if (ctl.step) begin
         reach_in = reach_ff | (near & ~blk_ff);
      end
   end

   assign grew  = ctl.step && ((near & ~blk_ff & ~reach_ff) != '0);
   assign reach = reach_ff;
   assign blk   = blk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_ff   <= '0;
         reach_ff <= '0;
      end else begin
         blk_ff   <= blk_in;
         reach_ff <= reach_in;
      end
   end
endmodule

FILE: hw/rtl/grid_bfs_distance_map.sv
// ----------------------------------------------------------------------------
// grid_bfs_distance_map
// Lee wavefront distance map over a 32 x 16 obstacle grid.
// ----------------------------------------------------------------------------
// A write is taken while idle and leaves the block idle; a read passes through
// the read state, and its answer is registered from the memory read registers
// into the response register. A compute clears the map, seeds the source and
// then grows the wavefront by one layer per step in a column of row cells;
// each newly reached cell stores the layer number in the distance memory
// through a one-cell-a-cycle drain of the new layer. req_ready stays low until
// a step reaches no new cell (a blocked source gives one empty layer).
`include "assert_macros.svh"
module grid_bfs_distance_map
   import gbfs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [0:0]    csr_index,
   input  logic [XW-1:0] csr_data
);
   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SEED  = 5'b00010,
      S_STEP  = 5'b00100,
      S_DRAIN = 5'b01000,
      S_READ  = 5'b10000
   } state_type;

   localparam int CellCount = GridWidth * GridHeight;
   localparam int AW = XW + YW;

   state_type state_ff, state_in;
   logic [XW-1:0] src_x_ff;
   logic [YW-1:0] src_y_ff;
   logic [11:0]   layer_ff, layer_in;
   logic [GridWidth*GridHeight-1:0] done_ff, done_in, reach_all, blk_all, pend;
   logic [GridHeight-1:0] grew;
   logic [GridWidth-1:0]  reach_r [GridHeight];
   logic [GridWidth-1:0]  blk_r   [GridHeight];
   row_ctl_type ctl;
   logic [11:0] dmem [CellCount];
   logic [11:0] rd_ff;
   logic        rd_blk_ff, rd_done_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   logic [AW-1:0] pick;
   logic          pick_ok;
   logic          accept;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         src_x_ff <= '0;
         src_y_ff <= YW'(8);
      end else if (csr_valid) begin
         case (csr_index)
            REG_SRC_X: src_x_ff <= csr_data;
            REG_SRC_Y: src_y_ff <= csr_data[YW-1:0];
            default: ;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE) && !(rsp_valid_ff && !rsp_ready);
   assign accept    = req_valid && req_ready;

   // Row chain
   always_comb begin
      ctl        = '0;
      ctl.clear  = accept && req_data.operation == OP_COMPUTE;
      ctl.seed   = state_ff == S_SEED;
      ctl.step   = state_ff == S_STEP;
      ctl.wr     = accept && req_data.operation == OP_WRITE
                   && {1'b0, req_data.cell_x} < (XW+1)'(GridWidth)
                   && {1'b0, req_data.cell_y} < (YW+1)'(GridHeight);
      ctl.wr_x   = req_data.cell_x;
      ctl.wr_y   = req_data.cell_y;
      ctl.wr_blk = req_data.blocked;
      ctl.src_x  = src_x_ff;
      ctl.src_y  = src_y_ff;
   end

   for (genvar r = 0; r < GridHeight; r++) begin : g_row
      gbfs_row u_row (
         .clock      (clock),
         .reset      (reset),
         .row_id     (YW'(r)),
         .ctl        (ctl),
         .above_reach((r == 0) ? '0 : reach_r[(r == 0) ? 0 : r-1]),
         .below_reach((r == GridHeight-1) ? '0 : reach_r[(r == GridHeight-1) ? r : r+1]),
         .reach      (reach_r[r]),
         .blk        (blk_r[r]),
         .grew       (grew[r])
      );
      assign reach_all[r*GridWidth +: GridWidth] = reach_r[r];
      assign blk_all[r*GridWidth +: GridWidth]   = blk_r[r];
   end

   // Newly reached cells not yet written to the distance memory
   assign pend = reach_all & ~done_ff;
   always_comb begin
      pick    = '0;
      pick_ok = 1'b0;
      for (int i = CellCount-1; i >= 0; i--) begin
         if (pend[i]) begin
            pick    = AW'(i);
            pick_ok = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      layer_in = layer_ff;
      done_in  = done_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.operation)
                  OP_COMPUTE: begin
                     state_in = S_SEED;
                     done_in  = '0;
                     layer_in = 12'd1;
                  end
                  OP_READ: state_in = S_READ;
                  default: ;
               endcase
            end
         end
         S_SEED:  state_in = S_DRAIN;
         S_DRAIN: begin
            if (pick_ok) begin
               done_in[pick] = 1'b1;
            end else begin
               state_in = S_STEP;
               layer_in = layer_ff + 12'd1;
            end
         end
         S_STEP: state_in = (grew != '0) ? S_DRAIN : S_IDLE;
         S_READ: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      layer_ff <= layer_in;
   end

   // Distance memory: written during drain, read for a read request
   always_ff @(posedge clock) begin
      if (state_ff == S_DRAIN && pick_ok) begin
         dmem[pick] <= layer_ff;
      end
      rd_ff      <= dmem[{req_data.cell_y, req_data.cell_x}];
      rd_blk_ff  <= blk_all[{req_data.cell_y, req_data.cell_x}];
      rd_done_ff <= done_ff[{req_data.cell_y, req_data.cell_x}];
   end

   // Response register; request fields still held from acceptance
   logic [XW-1:0] rx_ff;
   logic [YW-1:0] ry_ff;
   always_ff @(posedge clock) begin
      if (accept) begin
         rx_ff <= req_data.cell_x;
         ry_ff <= req_data.cell_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_READ) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (state_ff == S_READ) begin
         if ({1'b0, rx_ff} >= (XW+1)'(GridWidth)
             || {1'b0, ry_ff} >= (YW+1)'(GridHeight)) begin
            rsp_ff <= '{distance: '0, cell_state: ST_UNREACH};
         end else if (rd_blk_ff) begin
            rsp_ff <= '{distance: '0, cell_state: ST_BLOCKED};
         end else if (rd_done_ff) begin
            rsp_ff <= '{distance: (rd_ff > 12'd1023) ? DW'(1023) : rd_ff[DW-1:0],
                        cell_state: ST_REACH};
         end else begin
            rsp_ff <= '{distance: '0, cell_state: ST_UNREACH};
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped")
   `ASSERT_CLK(a_read_rsp, clock, reset, state_ff == S_READ |=> rsp_valid, "read lost")
   `ASSERT_CLK(a_idle_ready, clock, reset, req_ready |-> state_ff == S_IDLE, "ready busy")
endmodule
